>>> sv/assert_macros.svh
// Assertion macros for the checker file of the page bitmap allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define PBA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define PBA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/pba_pkg.sv
// Package of the page bitmap allocator: beat types, codes and defaults,
// and the command/status bundles between controller and datapath. No deps.
package pba_pkg;

  // defaults for the top-level parameters
  localparam int DEF_NUM_PAGES  = 32768;
  localparam int DEF_PAGE_BYTES = 4096;

  // map word read or written per cycle
  localparam int MAP_WORD_BITS = 64;

  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] RESERVED_RESET = 16'd4096;

  // item commands
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  // configuration register indexes
  localparam logic CFG_BASE_ADDRESS   = 1'b0;
  localparam logic CFG_RESERVED_PAGES = 1'b1;

  typedef struct packed {
    logic [1:0]         command;
    logic [COUNT_W-1:0] page_count;
    logic [ADDR_W-1:0]  address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] result_address;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic       scan_start;   // restart the first-fit scan at word zero
    logic       scan_en;      // scan in progress
    logic       load_range;   // latch the run to mark and its first word
    logic       mark_wr;      // write back the modified map word
    logic       sweep_start;  // start an init sweep
    logic       sweep_en;     // sweep writes one word
    logic       sweep_all;    // sweep marks every page free
    logic       finish;       // result goes to the output register
    logic [1:0] fin_status;
    logic       fin_addr;     // result carries the allocated address
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] command;
    logic       alloc_bad;
    logic       free_bad;
    logic       free_zero;
    logic       scan_found;
    logic       scan_end;
    logic       mark_last;
    logic       sweep_last;
  } dp_stat_t;

endpackage

>>> sv/pba_ctrl.sv
// Controller of the page bitmap allocator: sequences decode, scan, mark
// and sweep. Depends on pba_pkg.
module pba_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 out_free,
  input  pba_pkg::dp_stat_t    stat,
  output logic                 idle,
  output pba_pkg::ctrl_cmd_t   cmd
);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_PREP    = 4'd2;
  localparam logic [3:0] S_DECIDE  = 4'd3;
  localparam logic [3:0] S_SCAN    = 4'd4;
  localparam logic [3:0] S_MARK_RD = 4'd5;
  localparam logic [3:0] S_MARK_WR = 4'd6;
  localparam logic [3:0] S_SWEEP   = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] res_status_r, res_status_nxt;
  logic       res_addr_r, res_addr_nxt;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    cmd            = '0;
    cmd.fin_status = res_status_r;
    cmd.fin_addr   = res_addr_r;
    idle           = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.sweep_en  = 1'b1;
        cmd.sweep_all = 1'b1;
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        idle = 1'b1;
        if (accept) state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        res_status_nxt = pba_pkg::ST_OK;
        res_addr_nxt   = 1'b0;
        case (stat.command)
          pba_pkg::CMD_ALLOC: begin
            if (stat.alloc_bad) begin
              res_status_nxt = pba_pkg::ST_NOSPACE;
              state_nxt      = S_DONE;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          pba_pkg::CMD_FREE: begin
            if (stat.free_bad) begin
              res_status_nxt = pba_pkg::ST_BADFREE;
              state_nxt      = S_DONE;
            end else if (stat.free_zero) begin
              state_nxt = S_DONE;
            end else begin
              cmd.load_range = 1'b1;
              state_nxt      = S_MARK_RD;
            end
          end
          pba_pkg::CMD_INIT: begin
            cmd.sweep_start = 1'b1;
            state_nxt       = S_SWEEP;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (stat.scan_found) begin
          cmd.load_range = 1'b1;
          state_nxt      = S_MARK_RD;
        end else if (stat.scan_end) begin
          res_status_nxt = pba_pkg::ST_NOSPACE;
          state_nxt      = S_DONE;
        end
      end
      S_MARK_RD: begin
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        cmd.mark_wr = 1'b1;
        if (stat.mark_last) begin
          res_addr_nxt = (stat.command == pba_pkg::CMD_ALLOC);
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_MARK_RD;
        end
      end
      S_SWEEP: begin
        cmd.sweep_en = 1'b1;
        if (stat.sweep_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
  end

endmodule

>>> sv/pba_datapath.sv
// Datapath of the page bitmap allocator: free map memory, first-fit scan,
// run marking, init sweep and configuration registers. Depends on pba_pkg.
module pba_datapath #(
  parameter int NUM_PAGES  = pba_pkg::DEF_NUM_PAGES,
  parameter int PAGE_BYTES = pba_pkg::DEF_PAGE_BYTES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  pba_pkg::in_item_t             item,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [pba_pkg::ADDR_W-1:0]    cfg_wdata,
  input  pba_pkg::ctrl_cmd_t            cmd,
  output pba_pkg::dp_stat_t             stat,
  output logic [pba_pkg::ADDR_W-1:0]    alloc_addr
);

  localparam int W     = pba_pkg::MAP_WORD_BITS;
  localparam int LW    = $clog2(W);
  localparam int WORDS = NUM_PAGES / W;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW    = $clog2(NUM_PAGES) + 1;
  localparam int PBL   = $clog2(PAGE_BYTES);
  localparam int XW    = CW + pba_pkg::COUNT_W;
  localparam int AD    = pba_pkg::ADDR_W;

  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [AD-1:0] NUM_A     = AD'(NUM_PAGES);
  localparam logic [XW-1:0] NUM_X     = XW'(NUM_PAGES);
  localparam logic [CW-1:0] NUM_C     = CW'(NUM_PAGES);

  // free map: one bit per page, 1 = free
  logic [W-1:0] map_mem [WORDS];
  logic [W-1:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [W-1:0]  wr_data;

  // item and configuration
  logic [1:0]                  cmd_r, cmd_nxt;
  logic [pba_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [AD-1:0]               addr_r, addr_nxt;
  logic [AD-1:0]               base_r, base_nxt;
  logic [pba_pkg::COUNT_W-1:0] resv_r, resv_nxt;

  // free range check, registered in the cycle before the decision
  logic          below_r, below_nxt;
  logic [AD-1:0] page_w_r, page_w_nxt;

  // scan pipeline
  logic [AW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic          issued_last_r, issued_last_nxt;
  logic          rvld_r, rvld_nxt;
  logic [AW-1:0] rword_r, rword_nxt;
  logic [CW-1:0] run_r, run_nxt;

  // run to mark, sweep limit, word pointer for mark and sweep
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [AW-1:0] mark_ptr_r, mark_ptr_nxt;

  logic [CW-1:0] cnt_c;
  logic [CW-1:0] word_base;
  logic          zf_a  [W];
  logic [LW-1:0] lz_a  [W];
  logic [CW-1:0] len_a [W];
  logic [W-1:0]  hit;
  logic [LW-1:0] hit_pos;
  logic          found;
  logic [CW-1:0] scan_lo, scan_hi;
  logic [CW-1:0] free_lo, free_hi;
  logic [CW-1:0] range_lo;
  logic [W-1:0]  mark_mask;
  logic [W-1:0]  sweep_word;
  logic [CW-1:0] page_j;

  assign cnt_c     = CW'(cnt_r);
  assign word_base = CW'(rword_r) << LW;

  // run length ending at each bit of the word under scan
  always_comb begin
    for (int j = 0; j < W; j++) begin
      zf_a[j] = 1'b0;
      lz_a[j] = '0;
      for (int i = 0; i <= j; i++) begin
        if (!rdata_r[i]) begin
          zf_a[j] = 1'b1;
          lz_a[j] = LW'(i);
        end
      end
      if (!rdata_r[j]) begin
        len_a[j] = '0;
      end else if (zf_a[j]) begin
        len_a[j] = CW'(j) - CW'(lz_a[j]);
      end else begin
        len_a[j] = run_r + CW'(j) + CW'(1);
      end
      hit[j] = rdata_r[j] && (len_a[j] >= cnt_c);
    end
  end

  // lowest bit where the run first reaches the count
  always_comb begin
    hit_pos = '0;
    for (int j = W - 1; j >= 0; j--) begin
      if (hit[j]) hit_pos = LW'(j);
    end
  end

  assign found   = |hit;
  assign scan_hi = word_base + CW'(hit_pos);
  assign scan_lo = scan_hi + CW'(1) - cnt_c;
  assign free_lo = CW'(page_w_r);
  assign free_hi = free_lo + cnt_c - CW'(1);
  assign range_lo = (cmd_r == pba_pkg::CMD_ALLOC) ? scan_lo : free_lo;

  // per-bit masks for the word at the mark/sweep pointer
  always_comb begin
    page_j = '0;
    for (int j = 0; j < W; j++) begin
      page_j        = (CW'(mark_ptr_r) << LW) + CW'(j);
      mark_mask[j]  = (page_j >= lo_r) && (page_j <= hi_r);
      sweep_word[j] = cmd.sweep_all || (page_j >= lim_r);
    end
  end

  // map write port (always at the mark pointer) and read address
  always_comb begin
    wr_en   = cmd.sweep_en || cmd.mark_wr;
    wr_data = sweep_word;
    if (cmd.mark_wr) begin
      wr_data = (cmd_r == pba_pkg::CMD_FREE) ? (rdata_r | mark_mask)
                                             : (rdata_r & ~mark_mask);
    end
    rd_addr = cmd.scan_en ? scan_ptr_r : mark_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[mark_ptr_r] <= wr_data;
    rdata_r <= map_mem[rd_addr];
  end

  // next-state logic of the datapath registers
  always_comb begin
    cmd_nxt         = cmd_r;
    cnt_nxt         = cnt_r;
    addr_nxt        = addr_r;
    base_nxt        = base_r;
    resv_nxt        = resv_r;
    scan_ptr_nxt    = scan_ptr_r;
    issued_last_nxt = issued_last_r;
    rvld_nxt        = 1'b0;
    rword_nxt       = rword_r;
    run_nxt         = run_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    lim_nxt         = lim_r;
    mark_ptr_nxt    = mark_ptr_r;

    // free address check
    below_nxt  = addr_r < base_r;
    page_w_nxt = (addr_r - base_r) >> PBL;

    if (load) begin
      cmd_nxt  = item.command;
      cnt_nxt  = item.page_count;
      addr_nxt = item.address;
    end

    if (cfg_wr_en) begin
      if (cfg_index == pba_pkg::CFG_BASE_ADDRESS) begin
        base_nxt = cfg_wdata;
      end else begin
        resv_nxt = cfg_wdata[pba_pkg::COUNT_W-1:0];
      end
    end

    // scan: one word read per cycle, processed the cycle after
    if (cmd.scan_start) begin
      scan_ptr_nxt    = '0;
      issued_last_nxt = 1'b0;
      run_nxt         = '0;
    end else if (cmd.scan_en) begin
      if (!issued_last_r) begin
        rvld_nxt        = 1'b1;
        rword_nxt       = scan_ptr_r;
        issued_last_nxt = (scan_ptr_r == LAST_WORD);
        if (scan_ptr_r != LAST_WORD) scan_ptr_nxt = scan_ptr_r + AW'(1);
      end
      if (rvld_r) run_nxt = len_a[W-1];
    end

    // latch run bounds
    if (cmd.load_range) begin
      lo_nxt       = range_lo;
      hi_nxt       = (cmd_r == pba_pkg::CMD_ALLOC) ? scan_hi : free_hi;
      mark_ptr_nxt = AW'(range_lo >> LW);
    end

    if (cmd.mark_wr && (mark_ptr_r != AW'(hi_r >> LW))) begin
      mark_ptr_nxt = mark_ptr_r + AW'(1);
    end

    // init sweep: all pages below the limit go used, the rest go free
    if (cmd.sweep_start) begin
      mark_ptr_nxt = '0;
      lim_nxt = ({{CW{1'b0}}, resv_r} > NUM_X) ? NUM_C : CW'(resv_r);
    end else if (cmd.sweep_en && (mark_ptr_r != LAST_WORD)) begin
      mark_ptr_nxt = mark_ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= '0;
      resv_r        <= pba_pkg::RESERVED_RESET;
      scan_ptr_r    <= '0;
      issued_last_r <= 1'b0;
      rvld_r        <= 1'b0;
      mark_ptr_r    <= '0;
    end else begin
      base_r        <= base_nxt;
      resv_r        <= resv_nxt;
      scan_ptr_r    <= scan_ptr_nxt;
      issued_last_r <= issued_last_nxt;
      rvld_r        <= rvld_nxt;
      mark_ptr_r    <= mark_ptr_nxt;
    end
    cmd_r    <= cmd_nxt;
    cnt_r    <= cnt_nxt;
    addr_r   <= addr_nxt;
    below_r  <= below_nxt;
    page_w_r <= page_w_nxt;
    rword_r  <= rword_nxt;
    run_r    <= run_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    lim_r    <= lim_nxt;
  end

  // status to the controller
  always_comb begin
    stat.command    = cmd_r;
    stat.alloc_bad  = (cnt_r == '0) || ({{CW{1'b0}}, cnt_r} > NUM_X);
    stat.free_bad   = below_r || (page_w_r > NUM_A) ||
                      ((page_w_r + AD'(cnt_r)) > NUM_A);
    stat.free_zero  = (cnt_r == '0);
    stat.scan_found = rvld_r && found;
    stat.scan_end   = rvld_r && !found && (rword_r == LAST_WORD);
    stat.mark_last  = (mark_ptr_r == AW'(hi_r >> LW));
    stat.sweep_last = (mark_ptr_r == LAST_WORD);
  end

  // allocated address wraps modulo 2^48
  assign alloc_addr = base_r + (AD'(lo_r) << PBL);

endmodule

>>> sv/page_bitmap_allocator_unit.sv
// First-fit page allocator over a one-bit-per-page free map held in a
// single-port memory of 64-bit words (NUM_PAGES/64 words). Each item gives
// exactly one result beat. Timing is set by the one map port: an allocate
// decodes the item, reads map words in order until a run fits or the map
// ends, then reads and writes back each map word the new run touches; a
// free checks its range, then reads and writes back each word touched; an
// init writes every map word; rejected items go straight to the result.
// After reset a clearing pass over all NUM_PAGES/64 words sets every page
// free, with in_stall high; configuration writes are taken throughout. A
// new item is taken while a finished result still waits on out_stall.
// Depends on pba_pkg, pba_ctrl and pba_datapath.
module page_bitmap_allocator_unit #(
  parameter int NUM_PAGES  = pba_pkg::DEF_NUM_PAGES,
  parameter int PAGE_BYTES = pba_pkg::DEF_PAGE_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pba_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pba_pkg::out_item_t          out_item,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [pba_pkg::ADDR_W-1:0]  cfg_wdata
);

  pba_pkg::ctrl_cmd_t            cmd;
  pba_pkg::dp_stat_t             stat;
  logic                          idle;
  logic                          accept;
  logic                          out_free;
  logic [pba_pkg::ADDR_W-1:0]    alloc_addr;
  logic                          out_valid_r, out_valid_nxt;
  pba_pkg::out_item_t            out_item_r, out_item_nxt;

  // input handshake
  assign in_stall = !idle;
  assign accept   = in_valid && idle;

  // output register frees up when empty or taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (cmd.finish) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.status         = cmd.fin_status;
      out_item_nxt.result_address = cmd.fin_addr ? alloc_addr : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .out_free (out_free),
    .stat     (stat),
    .idle     (idle),
    .cmd      (cmd)
  );

  pba_datapath #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .item       (in_item),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .alloc_addr (alloc_addr)
  );

endmodule

>>> sv/pba_checker.sv
// Port-level checker for the page bitmap allocator, bound to the top level.
// Depends on pba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pba_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input pba_pkg::in_item_t           in_item,
  input logic                        out_valid,
  input logic                        out_stall,
  input pba_pkg::out_item_t          out_item,
  input logic                        cfg_wr_en,
  input logic                        cfg_index,
  input logic [pba_pkg::ADDR_W-1:0]  cfg_wdata
);

  // a stalled result beat holds
  `PBA_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_item), "result beat changed under stall")

  // only defined status codes leave the block
  `PBA_ASSERT(a_status_code, clk, rst_n, out_valid |-> (out_item.status == pba_pkg::ST_OK || out_item.status == pba_pkg::ST_NOSPACE || out_item.status == pba_pkg::ST_BADFREE), "undefined status code")

  // an address only comes with an ok status
  `PBA_ASSERT(a_addr_zero, clk, rst_n, out_valid && (out_item.status != pba_pkg::ST_OK) |-> (out_item.result_address == '0), "address on failed item")

  // just after reset: no item taken, no result shown
  `PBA_ASSERT_NR(a_reset_quiet, clk, !rst_n |=> in_stall && !out_valid, "item or result right after reset")

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);
